// File: src/lr_pkg.sv
// ----------------------------------------------------------------------------
// lr_pkg
// Shared constants and types for the line rasterizer.
// ----------------------------------------------------------------------------
package lr_pkg;

    localparam int COORD_BITS_DEF  = 10;
    localparam int COLOUR_BITS_DEF = 16;
    localparam int QUEUE_DEPTH_DEF = 2;

    // command codes
    localparam logic CMD_START = 1'b0;
    localparam logic CMD_NEXT  = 1'b1;

    // decoded command and stepping directions, front to back
    typedef struct packed {
        logic start;
        logic x_neg;
        logic y_neg;
        logic x_major;
    } lr_ctrl_t;

endpackage

// File: src/lr_front.sv
// ----------------------------------------------------------------------------
// lr_front
// Decodes a command and works out the line setup for a start command.
// ----------------------------------------------------------------------------
module lr_front #(
    parameter int COORD_BITS = lr_pkg::COORD_BITS_DEF
) (
    input  logic                          command,
    input  logic [COORD_BITS-1:0]         start_x,
    input  logic [COORD_BITS-1:0]         start_y,
    input  logic [COORD_BITS-1:0]         end_x,
    input  logic [COORD_BITS-1:0]         end_y,
    output lr_pkg::lr_ctrl_t              ctrl,
    output logic [COORD_BITS-1:0]         first_x,
    output logic [COORD_BITS-1:0]         first_y,
    output logic [COORD_BITS-1:0]         major,
    output logic [COORD_BITS:0]           straight_inc,
    output logic signed [COORD_BITS+1:0]  error_init,
    output logic signed [COORD_BITS+1:0]  diagonal_inc
);

    logic [COORD_BITS-1:0] x0;
    logic [COORD_BITS-1:0] y0;
    logic [COORD_BITS-1:0] x1;
    logic [COORD_BITS-1:0] y1;
    logic [COORD_BITS-1:0] dx;
    logic [COORD_BITS-1:0] dy;
    logic [COORD_BITS-1:0] minor;
    logic                  x_neg;
    logic                  y_neg;
    logic                  x_major;

    always_comb
    begin
        x0 = start_x;
        y0 = start_y;
        x1 = end_x;
        y1 = end_y;
        // straight lines always run upward from the smaller coordinate
        if (start_x == end_x && end_y < start_y)
        begin
            y0 = end_y;
            y1 = start_y;
        end
        else if (start_y == end_y && end_x < start_x)
        begin
            x0 = end_x;
            x1 = start_x;
        end
        x_neg   = x1 < x0;
        y_neg   = y1 < y0;
        dx      = x_neg ? (x0 - x1) : (x1 - x0);
        dy      = y_neg ? (y0 - y1) : (y1 - y0);
        x_major = dx >= dy;
        major   = x_major ? dx : dy;
        minor   = x_major ? dy : dx;
    end

    assign straight_inc = {minor, 1'b0};
    assign error_init   = $signed({1'b0, straight_inc}) - $signed({2'b00, major});
    assign diagonal_inc = error_init - $signed({2'b00, major});

    assign first_x = x0;
    assign first_y = y0;

    assign ctrl.start   = (command == lr_pkg::CMD_START);
    assign ctrl.x_neg   = x_neg;
    assign ctrl.y_neg   = y_neg;
    assign ctrl.x_major = x_major;

endmodule

// File: src/lr_queue.sv
// ----------------------------------------------------------------------------
// lr_queue
// Small register FIFO between the command front end and the stepper.
// ----------------------------------------------------------------------------
module lr_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = lr_pkg::QUEUE_DEPTH_DEF
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             wr_valid,
    output logic             wr_ready,
    input  logic [WIDTH-1:0] wr_data,
    output logic             rd_valid,
    input  logic             rd_ready,
    output logic [WIDTH-1:0] rd_data
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [PTR_W-1:0] PTR_ONE  = PTR_W'(1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);
    localparam logic [CNT_W-1:0] CNT_ONE  = CNT_W'(1);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             push;
    logic             pop;

    assign wr_ready = (count_reg != CNT_FULL);
    assign rd_valid = (count_reg != '0);
    assign rd_data  = mem[rd_ptr_reg];
    assign push     = wr_valid && wr_ready;
    assign pop      = rd_valid && rd_ready;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + PTR_ONE;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + PTR_ONE;
        end
        if (push && !pop)
        begin
            count_next = count_reg + CNT_ONE;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - CNT_ONE;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

// File: src/lr_back.sv
// ----------------------------------------------------------------------------
// lr_back
// Bresenham stepper: holds the line state and emits one pixel per command.
// ----------------------------------------------------------------------------
module lr_back #(
    parameter int COORD_BITS  = lr_pkg::COORD_BITS_DEF,
    parameter int COLOUR_BITS = lr_pkg::COLOUR_BITS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          q_valid,
    output logic                          q_ready,
    input  lr_pkg::lr_ctrl_t              ctrl,
    input  logic [COORD_BITS-1:0]         first_x,
    input  logic [COORD_BITS-1:0]         first_y,
    input  logic [COORD_BITS-1:0]         major,
    input  logic [COORD_BITS:0]           straight_inc,
    input  logic signed [COORD_BITS+1:0]  error_init,
    input  logic signed [COORD_BITS+1:0]  diagonal_inc,
    input  logic [COLOUR_BITS-1:0]        colour,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic                          pixel_valid,
    output logic [COORD_BITS-1:0]         pixel_x,
    output logic [COORD_BITS-1:0]         pixel_y,
    output logic [COLOUR_BITS-1:0]        pixel_colour,
    output logic                          last_pixel
);

    localparam int ERR_W = COORD_BITS + 3;
    localparam logic [COORD_BITS-1:0] ONE = COORD_BITS'(1);

    // line state
    logic [COORD_BITS-1:0]    cur_x_reg,    cur_x_next;
    logic [COORD_BITS-1:0]    cur_y_reg,    cur_y_next;
    logic signed [ERR_W-1:0]  err_reg,      err_next;
    logic [COORD_BITS:0]      str_reg;
    logic signed [COORD_BITS+1:0] diag_reg;
    logic [COORD_BITS-1:0]    left_reg;
    logic                     x_neg_reg;
    logic                     y_neg_reg;
    logic                     x_major_reg;
    logic [COLOUR_BITS-1:0]   colour_reg;
    logic                     active_reg;

    // output register
    logic                     out_valid_reg;
    logic                     out_pvalid_reg;
    logic [COORD_BITS-1:0]    out_x_reg;
    logic [COORD_BITS-1:0]    out_y_reg;
    logic [COLOUR_BITS-1:0]   out_colour_reg;
    logic                     out_last_reg;

    // selected source state for this transaction
    logic [COORD_BITS-1:0]    s_x;
    logic [COORD_BITS-1:0]    s_y;
    logic signed [ERR_W-1:0]  s_err;
    logic [COORD_BITS:0]      s_str;
    logic signed [COORD_BITS+1:0] s_diag;
    logic [COORD_BITS-1:0]    s_left;
    logic                     s_x_neg;
    logic                     s_y_neg;
    logic                     s_x_major;
    logic [COLOUR_BITS-1:0]   s_colour;
    logic                     emit;
    logic                     minor_step;
    logic                     take;

    assign q_ready = !out_valid_reg || out_ready;
    assign take    = q_valid && q_ready;

    always_comb
    begin
        s_x       = cur_x_reg;
        s_y       = cur_y_reg;
        s_err     = err_reg;
        s_str     = str_reg;
        s_diag    = diag_reg;
        s_left    = left_reg - ONE;
        s_x_neg   = x_neg_reg;
        s_y_neg   = y_neg_reg;
        s_x_major = x_major_reg;
        s_colour  = colour_reg;
        emit      = active_reg;
        if (ctrl.start)
        begin
            s_x       = first_x;
            s_y       = first_y;
            s_err     = {error_init[COORD_BITS+1], error_init};
            s_str     = straight_inc;
            s_diag    = diagonal_inc;
            s_left    = major;
            s_x_neg   = ctrl.x_neg;
            s_y_neg   = ctrl.y_neg;
            s_x_major = ctrl.x_major;
            s_colour  = colour;
            emit      = 1'b1;
        end

        // advance past the pixel being emitted
        minor_step = !s_err[ERR_W-1];
        err_next   = minor_step ? s_err + {s_diag[COORD_BITS+1], s_diag}
                                : s_err + $signed({2'b00, s_str});
        cur_x_next = s_x;
        cur_y_next = s_y;
        if (s_x_major || minor_step)
        begin
            cur_x_next = s_x_neg ? s_x - ONE : s_x + ONE;
        end
        if (!s_x_major || minor_step)
        begin
            cur_y_next = s_y_neg ? s_y - ONE : s_y + ONE;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_x_reg     <= '0;
            cur_y_reg     <= '0;
            err_reg       <= '0;
            str_reg       <= '0;
            diag_reg      <= '0;
            left_reg      <= '0;
            x_neg_reg     <= 1'b0;
            y_neg_reg     <= 1'b0;
            x_major_reg   <= 1'b0;
            colour_reg    <= '0;
            active_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (take && emit)
            begin
                cur_x_reg   <= cur_x_next;
                cur_y_reg   <= cur_y_next;
                err_reg     <= err_next;
                str_reg     <= s_str;
                diag_reg    <= s_diag;
                left_reg    <= s_left;
                x_neg_reg   <= s_x_neg;
                y_neg_reg   <= s_y_neg;
                x_major_reg <= s_x_major;
                colour_reg  <= s_colour;
                active_reg  <= (s_left != '0);
            end
            if (take)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            // idle next command gives an all-zero result
            out_pvalid_reg <= emit;
            out_x_reg      <= emit ? s_x : '0;
            out_y_reg      <= emit ? s_y : '0;
            out_colour_reg <= emit ? s_colour : '0;
            out_last_reg   <= emit && (s_left == '0);
        end
    end

    assign out_valid    = out_valid_reg;
    assign pixel_valid  = out_pvalid_reg;
    assign pixel_x      = out_x_reg;
    assign pixel_y      = out_y_reg;
    assign pixel_colour = out_colour_reg;
    assign last_pixel   = out_last_reg;

endmodule

// File: src/line_rasterizer.sv
// ----------------------------------------------------------------------------
// line_rasterizer
// Bresenham line generator, one pixel per command transaction.
// ----------------------------------------------------------------------------
// Every command transaction gives exactly one result transaction. A start
// command loads the endpoints and colour and returns the first pixel; each
// next command returns the following pixel, the final one with tlast set. A
// next command with no line active returns a result with tuser (pixel valid)
// low and all other fields zero. While the output is not stalled, the block
// takes one command per clock and delivers one pixel per clock: the stepper
// does one add and compare on the error term per pixel. A command passes
// through the command queue and then the output register on its way out; the
// queue, QUEUE_DEPTH entries deep, keeps commands flowing in while the output
// is stalled.
module line_rasterizer #(
    parameter int COORD_BITS  = lr_pkg::COORD_BITS_DEF,
    parameter int COLOUR_BITS = lr_pkg::COLOUR_BITS_DEF,
    parameter int QUEUE_DEPTH = lr_pkg::QUEUE_DEPTH_DEF
) (
    input  logic clk,
    input  logic rst_n,
    input  logic s_tvalid,
    output logic s_tready,
    // start_x, start_y, end_x, end_y, colour, zero padding
    input  logic [((4*COORD_BITS+COLOUR_BITS+7)/8)*8-1:0] s_tdata,
    // command
    input  logic s_tuser,
    output logic m_tvalid,
    input  logic m_tready,
    // pixel_x, pixel_y, pixel_colour, zero padding
    output logic [((2*COORD_BITS+COLOUR_BITS+7)/8)*8-1:0] m_tdata,
    // pixel_valid
    output logic m_tuser,
    // last_pixel
    output logic m_tlast
);

    localparam int CB      = COORD_BITS;
    localparam int DOUT_W  = ((2*CB+COLOUR_BITS+7)/8)*8;
    localparam int ENTRY_W = $bits(lr_pkg::lr_ctrl_t) + 6*CB + 5 + COLOUR_BITS;

    lr_pkg::lr_ctrl_t          f_ctrl,  b_ctrl;
    logic [CB-1:0]             f_x0,    b_x0;
    logic [CB-1:0]             f_y0,    b_y0;
    logic [CB-1:0]             f_major, b_major;
    logic [CB:0]               f_str,   b_str;
    logic signed [CB+1:0]      f_err,   b_err;
    logic signed [CB+1:0]      f_diag,  b_diag;
    logic [COLOUR_BITS-1:0]    b_colour;
    logic [ENTRY_W-1:0]        wr_entry;
    logic [ENTRY_W-1:0]        rd_entry;
    logic                      q_valid;
    logic                      q_ready;
    logic [CB-1:0]             px;
    logic [CB-1:0]             py;
    logic [COLOUR_BITS-1:0]    pcolour;

    lr_front #(
        .COORD_BITS (COORD_BITS)
    ) u_front (
        .command      (s_tuser),
        .start_x      (s_tdata[CB-1:0]),
        .start_y      (s_tdata[2*CB-1:CB]),
        .end_x        (s_tdata[3*CB-1:2*CB]),
        .end_y        (s_tdata[4*CB-1:3*CB]),
        .ctrl         (f_ctrl),
        .first_x      (f_x0),
        .first_y      (f_y0),
        .major        (f_major),
        .straight_inc (f_str),
        .error_init   (f_err),
        .diagonal_inc (f_diag)
    );

    assign wr_entry = {f_ctrl, f_x0, f_y0, f_major, f_str, f_err, f_diag,
                       s_tdata[4*CB+COLOUR_BITS-1:4*CB]};

    lr_queue #(
        .WIDTH (ENTRY_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_valid (s_tvalid),
        .wr_ready (s_tready),
        .wr_data  (wr_entry),
        .rd_valid (q_valid),
        .rd_ready (q_ready),
        .rd_data  (rd_entry)
    );

    assign {b_ctrl, b_x0, b_y0, b_major, b_str, b_err, b_diag, b_colour} = rd_entry;

    lr_back #(
        .COORD_BITS  (COORD_BITS),
        .COLOUR_BITS (COLOUR_BITS)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .q_valid      (q_valid),
        .q_ready      (q_ready),
        .ctrl         (b_ctrl),
        .first_x      (b_x0),
        .first_y      (b_y0),
        .major        (b_major),
        .straight_inc (b_str),
        .error_init   (b_err),
        .diagonal_inc (b_diag),
        .colour       (b_colour),
        .out_valid    (m_tvalid),
        .out_ready    (m_tready),
        .pixel_valid  (m_tuser),
        .pixel_x      (px),
        .pixel_y      (py),
        .pixel_colour (pcolour),
        .last_pixel   (m_tlast)
    );

    assign m_tdata = DOUT_W'({pcolour, py, px});

endmodule

// File: tb/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the line rasterizer: a directed table of commands,
// then random lines under four idle/stall phases, each pixel compared with a
// Bresenham tracker that follows every accepted command.
// ----------------------------------------------------------------------------
module tb_top;

    localparam int CW           = 10;
    localparam int KW           = 16;
    localparam int CMD_W        = 56;
    localparam int PIX_W        = 40;
    localparam int N_DIRECTED   = 25;
    localparam int PHASE_ITEMS  = 125;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int DRAIN_CYCLES = 10;
    localparam logic [CW-1:0] CMAX = '1;

    typedef struct packed {
        logic          valid;
        logic [CW-1:0] x;
        logic [CW-1:0] y;
        logic [KW-1:0] colour;
        logic          last;
    } pixel_t;

    typedef struct packed {
        logic          cmd;
        logic [CW-1:0] sx;
        logic [CW-1:0] sy;
        logic [CW-1:0] ex;
        logic [CW-1:0] ey;
        logic [KW-1:0] colour;
        logic          typed;
        pixel_t        want;
    } row_t;

    logic             clk = 1'b0;
    logic             rst_n = 1'b0;
    logic             s_tvalid = 1'b0;
    logic             s_tready;
    logic [CMD_W-1:0] s_tdata = '0;
    logic             s_tuser = 1'b0;
    logic             m_tvalid;
    logic             m_tready = 1'b0;
    logic [PIX_W-1:0] m_tdata;
    logic             m_tuser;
    logic             m_tlast;

    // line tracker state
    logic [CW-1:0]      pen_x, pen_y;
    logic signed [12:0] err_acc;
    logic [11:0]        straight_inc;
    logic signed [12:0] diag_inc;
    logic [10:0]        steps_left;
    logic               x_back, y_back, x_major;
    logic [KW-1:0]      pen_colour;
    logic               drawing;

    pixel_t expected_pixels[$];
    int     mismatches = 0;
    int     cycle_count = 0;
    int     commands_sent = 0;
    int     src_idle_pct = 0;
    int     sink_stall_pct = 0;
    row_t   directed_rows [N_DIRECTED];

    line_rasterizer DUT (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    initial
    begin
        forever #4 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    function automatic pixel_t current_pixel();
        pixel_t p;
        p.valid  = 1'b1;
        p.x      = pen_x;
        p.y      = pen_y;
        p.colour = pen_colour;
        p.last   = (steps_left == '0);
        return p;
    endfunction

    // one Bresenham step along the major axis, diagonal when the error is >= 0
    task automatic step_pen();
        logic diag;
        diag = (err_acc >= 0);
        if (diag)
            err_acc = err_acc + diag_inc;
        else
            err_acc = err_acc + $signed({1'b0, straight_inc});
        if (x_major || diag)
            pen_x = x_back ? pen_x - 1'b1 : pen_x + 1'b1;
        if (!x_major || diag)
            pen_y = y_back ? pen_y - 1'b1 : pen_y + 1'b1;
    endtask

    task automatic trace_pixel(input logic cmd, input logic [CMD_W-1:0] data,
                               output pixel_t pix);
        logic [CW-1:0] x0, y0, x1, y1, t, dx, dy, major, minor;
        int            e;
        x0 = data[9:0];
        y0 = data[19:10];
        x1 = data[29:20];
        y1 = data[39:30];
        if (cmd == lr_pkg::CMD_START)
        begin
            pen_colour = data[55:40];
            // axis-aligned lines always run upward
            if (x0 == x1 && y1 < y0)
            begin
                t = y0; y0 = y1; y1 = t;
            end
            else if (y0 == y1 && x1 < x0)
            begin
                t = x0; x0 = x1; x1 = t;
            end
            x_back  = (x1 < x0);
            y_back  = (y1 < y0);
            dx      = x_back ? x0 - x1 : x1 - x0;
            dy      = y_back ? y0 - y1 : y1 - y0;
            x_major = (dx >= dy);
            major   = x_major ? dx : dy;
            minor   = x_major ? dy : dx;
            e            = 2 * int'(minor) - int'(major);
            straight_inc = 12'(2 * int'(minor));
            err_acc      = 13'(e);
            diag_inc     = 13'(e - int'(major));
            steps_left   = 11'(major);
            pen_x        = x0;
            pen_y        = y0;
            pix          = current_pixel();
            drawing      = (steps_left != '0);
            step_pen();
        end
        else if (!drawing)
            pix = '0;
        else
        begin
            steps_left = steps_left - 1'b1;
            pix        = current_pixel();
            drawing    = (steps_left != '0);
            step_pen();
        end
    endtask

    // drive one command from a falling edge, return at the falling edge after it is taken
    task automatic send_command(input logic cmd, input logic [CMD_W-1:0] data,
                                input logic typed, input pixel_t typed_pixel);
        pixel_t pix;
        while ($urandom_range(99) < src_idle_pct)
        begin
            s_tvalid = 1'b0;
            @(negedge clk);
        end
        s_tvalid = 1'b1;
        s_tuser  = cmd;
        s_tdata  = data;
        do
            @(posedge clk);
        while (!s_tready);
        trace_pixel(cmd, data, pix);
        expected_pixels.push_back(typed ? typed_pixel : pix);
        commands_sent++;
        @(negedge clk);
        s_tvalid = 1'b0;
    endtask

    function automatic logic [CW-1:0] near_coord(logic [CW-1:0] c, int span);
        int v;
        v = int'(c) + $urandom_range(2 * span) - span;
        if (v < 0)
            v = 0;
        if (v > int'(CMAX))
            v = int'(CMAX);
        return CW'(v);
    endfunction

    // one start followed by a run of next commands, mostly to the end and a bit past
    task automatic draw_random_line();
        logic [CW-1:0] x0, y0, x1, y1, dx, dy;
        int            nexts;
        x0 = CW'($urandom);
        y0 = CW'($urandom);
        if ($urandom_range(9) == 0)
        begin
            x1 = CW'($urandom);
            y1 = CW'($urandom);
        end
        else
        begin
            x1 = near_coord(x0, 15);
            y1 = near_coord(y0, 15);
            case ($urandom_range(7))
                0: x1 = x0;
                1: y1 = y0;
                2: begin x1 = x0; y1 = y0; end
                default: ;
            endcase
        end
        dx = (x1 > x0) ? x1 - x0 : x0 - x1;
        dy = (y1 > y0) ? y1 - y0 : y0 - y1;
        if ($urandom_range(5) == 0)
            nexts = $urandom_range(12);
        else
            nexts = int'((dx > dy) ? dx : dy) + $urandom_range(2);
        if (nexts > 40)
            nexts = $urandom_range(40);
        send_command(lr_pkg::CMD_START, {16'($urandom), y1, x1, y0, x0}, 1'b0, '0);
        repeat (nexts)
            send_command(lr_pkg::CMD_NEXT, CMD_W'({$urandom, $urandom}), 1'b0, '0);
    endtask

    always @(negedge clk)
    begin
        if (rst_n)
            m_tready <= ($urandom_range(99) >= sink_stall_pct);
    end

    always @(posedge clk)
    begin
        pixel_t want;
        pixel_t got;
        if (rst_n && m_tvalid && m_tready)
        begin
            got = {m_tuser, m_tdata[9:0], m_tdata[19:10], m_tdata[35:20], m_tlast};
            if (expected_pixels.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected pixel transaction: valid=%0d x=%0d y=%0d c=%h last=%0d",
                             got.valid, got.x, got.y, got.colour, got.last);
            end
            else
            begin
                want = expected_pixels.pop_front();
                if (got !== want)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display({"pixel mismatch: expected valid=%0d x=%0d y=%0d c=%h last=%0d,",
                                  " got valid=%0d x=%0d y=%0d c=%h last=%0d"},
                                 want.valid, want.x, want.y, want.colour, want.last,
                                 got.valid, got.x, got.y, got.colour, got.last);
                end
            end
        end
    end

    initial
    begin
        directed_rows = '{
            '{lr_pkg::CMD_NEXT,  10'd0,  10'd0,  10'd0,  10'd0,  16'h0000, 1'b1, '0},
            '{lr_pkg::CMD_NEXT,  CMAX,   CMAX,   CMAX,   CMAX,   16'hFFFF, 1'b1, '0},
            '{lr_pkg::CMD_START, 10'd5,  10'd5,  10'd5,  10'd5,  16'hFFFF, 1'b1,
              '{1'b1, 10'd5, 10'd5, 16'hFFFF, 1'b1}},
            '{lr_pkg::CMD_NEXT,  10'd0,  10'd0,  10'd0,  10'd0,  16'h0000, 1'b1, '0},
            '{lr_pkg::CMD_START, 10'd0,  10'd0,  CMAX,   CMAX,   16'h0000, 1'b1,
              '{1'b1, 10'd0, 10'd0, 16'h0000, 1'b0}},
            '{lr_pkg::CMD_NEXT,  10'd0,  10'd0,  10'd0,  10'd0,  16'h0000, 1'b0, '0},
            '{lr_pkg::CMD_NEXT,  10'd0,  10'd0,  10'd0,  10'd0,  16'h0000, 1'b0, '0},
            // abandon the diagonal, vertical line given top to bottom
            '{lr_pkg::CMD_START, 10'd7,  CMAX,   10'd7,  10'd0,  16'hA5A5, 1'b1,
              '{1'b1, 10'd7, 10'd0, 16'hA5A5, 1'b0}},
            '{lr_pkg::CMD_NEXT,  10'd0,  10'd0,  10'd0,  10'd0,  16'h0000, 1'b0, '0},
            '{lr_pkg::CMD_START, CMAX,   10'd3,  10'd0,  10'd3,  16'h5A5A, 1'b1,
              '{1'b1, 10'd0, 10'd3, 16'h5A5A, 1'b0}},
            '{lr_pkg::CMD_NEXT,  10'd0,  10'd0,  10'd0,  10'd0,  16'h0000, 1'b0, '0},
            '{lr_pkg::CMD_START, CMAX,   10'd0,  10'd0,  CMAX,   16'h1234, 1'b1,
              '{1'b1, CMAX, 10'd0, 16'h1234, 1'b0}},
            '{lr_pkg::CMD_NEXT,  10'd0,  10'd0,  10'd0,  10'd0,  16'h0000, 1'b0, '0},
            '{lr_pkg::CMD_NEXT,  10'd0,  10'd0,  10'd0,  10'd0,  16'h0000, 1'b0, '0},
            '{lr_pkg::CMD_START, 10'd0,  CMAX,   CMAX,   10'd0,  16'hFFFF, 1'b1,
              '{1'b1, 10'd0, CMAX, 16'hFFFF, 1'b0}},
            '{lr_pkg::CMD_NEXT,  10'd0,  10'd0,  10'd0,  10'd0,  16'h0000, 1'b0, '0},
            // steep short line, run to the end and one past it
            '{lr_pkg::CMD_START, 10'd10, 10'd0,  10'd12, 10'd5,  16'h0F0F, 1'b1,
              '{1'b1, 10'd10, 10'd0, 16'h0F0F, 1'b0}},
            '{lr_pkg::CMD_NEXT,  10'd0,  10'd0,  10'd0,  10'd0,  16'h0000, 1'b0, '0},
            '{lr_pkg::CMD_NEXT,  10'd0,  10'd0,  10'd0,  10'd0,  16'h0000, 1'b0, '0},
            '{lr_pkg::CMD_NEXT,  10'd0,  10'd0,  10'd0,  10'd0,  16'h0000, 1'b0, '0},
            '{lr_pkg::CMD_NEXT,  10'd0,  10'd0,  10'd0,  10'd0,  16'h0000, 1'b0, '0},
            '{lr_pkg::CMD_NEXT,  10'd0,  10'd0,  10'd0,  10'd0,  16'h0000, 1'b0, '0},
            '{lr_pkg::CMD_NEXT,  CMAX,   CMAX,   CMAX,   CMAX,   16'hFFFF, 1'b1, '0},
            '{lr_pkg::CMD_START, CMAX,   CMAX,   CMAX,   CMAX,   16'h8001, 1'b1,
              '{1'b1, CMAX, CMAX, 16'h8001, 1'b1}},
            '{lr_pkg::CMD_NEXT,  10'd0,  10'd0,  10'd0,  10'd0,  16'h0000, 1'b1, '0}
        };

        pen_x = '0; pen_y = '0; err_acc = '0; straight_inc = '0; diag_inc = '0;
        steps_left = '0; x_back = 1'b0; y_back = 1'b0; x_major = 1'b0;
        pen_colour = '0; drawing = 1'b0;

        repeat (9) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        foreach (directed_rows[i])
            send_command(directed_rows[i].cmd,
                         {directed_rows[i].colour, directed_rows[i].ey, directed_rows[i].ex,
                          directed_rows[i].sy, directed_rows[i].sx},
                         directed_rows[i].typed, directed_rows[i].want);

        // phases: no idling, sender idle, receiver stalling, both
        for (int phase = 0; phase < 4; phase++)
        begin
            src_idle_pct   = (phase == 1) ? 52 : (phase == 3) ? 31 : 0;
            sink_stall_pct = (phase == 2) ? 52 : (phase == 3) ? 31 : 0;
            commands_sent  = 0;
            while (commands_sent < PHASE_ITEMS)
                draw_random_line();
        end

        while (expected_pixels.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatches == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
